// File: hdl/cssa_pkg.sv
`timescale 1ns / 1ps

package cssa_pkg;

	localparam int unsigned NEURONS_DEF      = 1024;
	localparam int unsigned MAX_SYNAPSES_DEF = 65536;

	typedef enum logic [1:0] {
		OP_ROW_START = 2'd0,
		OP_SYNAPSE   = 2'd1,
		OP_SPIKE     = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [10:0]         neuron;
		logic [15:0]         entry_slot;
		logic [16:0]         row_start;
		logic [9:0]          target_column;
		logic signed [15:0]  weight;
	} cmd_item_t;

	typedef struct packed {
		logic [9:0]          read_neuron;
		logic signed [31:0]  accumulated;
	} rsp_item_t;

	typedef struct packed {
		logic [9:0]          target;
		logic signed [15:0]  weight;
	} syn_t;

	typedef struct packed {
		logic add;
		logic rd;
		logic clr;
	} acc_cmd_t;

	typedef struct packed {
		logic init_busy;
		logic pipe_busy;
	} acc_stat_t;

endpackage

// File: hdl/cssa_acc_bank.sv
`timescale 1ns / 1ps

module cssa_acc_bank import cssa_pkg::*; #(
	parameter int unsigned NEURONS = NEURONS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  acc_cmd_t                     cmd,
	input  logic [$clog2(NEURONS)-1:0]   idx,
	input  syn_t                         syn,
	output logic signed [31:0]           rd_data,
	output acc_stat_t                    stat
);

	localparam int unsigned NA = $clog2(NEURONS);

	logic signed [31:0] mem [NEURONS];
	logic signed [31:0] rd_q;

	logic               init_q;
	logic [NA-1:0]      clr_cnt_q;

	logic               v_s2;
	logic [NA-1:0]      tgt_s2;
	logic signed [15:0] wt_s2;

	logic               fwd_v_q;
	logic [NA-1:0]      fwd_tgt_q;
	logic signed [31:0] fwd_data_q;

	logic [31:0]        tgt_ext;
	logic               tgt_ok;
	logic [NA-1:0]      tgt_idx;
	logic               rd_en;
	logic [NA-1:0]      rd_addr;
	logic signed [31:0] acc_eff;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum;
	logic               wr_en;
	logic [NA-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	assign tgt_ext = 32'(syn.target);
	assign tgt_ok  = tgt_ext < NEURONS;
	assign tgt_idx = tgt_ext[NA-1:0];

	assign rd_en   = cmd.rd || (cmd.add && tgt_ok);
	assign rd_addr = cmd.rd ? idx : tgt_idx;

	// The entry written on the previous edge is not yet visible in the read data.
	assign acc_eff  = (fwd_v_q && fwd_tgt_q == tgt_s2) ? fwd_data_q : rd_q;
	assign sum_wide = {acc_eff[31], acc_eff} + 33'(wt_s2);

	always_comb begin
		if (sum_wide[32] != sum_wide[31]) begin
			sum = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sum = sum_wide[31:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx;
		wr_data = '0;
		priority if (init_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
		end else if (v_s2) begin
			wr_en   = 1'b1;
			wr_addr = tgt_s2;
			wr_data = sum;
		end else if (cmd.clr) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		tgt_s2     <= tgt_idx;
		wt_s2      <= syn.weight;
		fwd_tgt_q  <= tgt_s2;
		fwd_data_q <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b1;
			clr_cnt_q <= '0;
			v_s2      <= 1'b0;
			fwd_v_q   <= 1'b0;
		end else begin
			if (init_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (32'(clr_cnt_q) == NEURONS - 1) begin
					init_q <= 1'b0;
				end
			end
			v_s2    <= cmd.add && tgt_ok;
			fwd_v_q <= v_s2;
		end
	end

	assign rd_data        = rd_q;
	assign stat.init_busy = init_q;
	assign stat.pipe_busy = v_s2;

endmodule

// File: hdl/csr_spike_scatter_accumulate_top.sv
// A row-start or synapse write is done at acceptance and leaves the block idle. A read waits in
// its read state until the result register is free, then loads its item into that register.
// A spike over a row of n >= 1 synapse entries passes through acceptance, two row-start reads,
// one entry a cycle from the entry memory port, then a drain of the accumulator read-modify-write
// pipeline; a spike over an empty row skips the entry reads and the drain.
// After reset the accumulator memory is cleared entry by entry, during which no item is accepted.
`timescale 1ns / 1ps

module csr_spike_scatter_accumulate_top import cssa_pkg::*; #(
	parameter int unsigned NEURONS      = NEURONS_DEF,
	parameter int unsigned MAX_SYNAPSES = MAX_SYNAPSES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int unsigned NA = $clog2(NEURONS);
	localparam int unsigned RW = $clog2(NEURONS + 1);
	localparam int unsigned EW = $clog2(MAX_SYNAPSES);
	localparam int unsigned PW = $clog2(MAX_SYNAPSES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW0,
		ST_ROW1,
		ST_WALK,
		ST_READ
	} state_t;

	logic [16:0] row_mem [NEURONS + 1];
	logic [16:0] row_rd_q;
	syn_t        ent_mem [MAX_SYNAPSES];
	syn_t        ent_rd_q;

	state_t      state_q;
	logic [10:0] neuron_q;
	logic [PW-1:0] start_q;
	logic [PW-1:0] end_q;
	logic [PW-1:0] ptr_q;
	logic        ent_v_s1;
	logic        rsp_valid_q;
	rsp_item_t   rsp_q;

	logic        accept;
	logic [31:0] neuron_ext;
	logic [31:0] neuron_q_ext;
	logic [31:0] next_row_ext;
	logic [31:0] slot_ext;
	logic        neuron_lt;
	logic        row_we;
	logic        ent_we;
	logic        row_re;
	logic [RW-1:0] row_rd_addr;
	logic        issue;
	logic        rsp_free;

	acc_cmd_t    acc_cmd;
	logic [NA-1:0] acc_idx;
	logic signed [31:0] acc_rd_data;
	acc_stat_t   acc_stat;

	function automatic logic [PW-1:0] clamp_offset(input logic [16:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w > MAX_SYNAPSES) begin
			w = MAX_SYNAPSES;
		end
		return w[PW-1:0];
	endfunction

	assign cmd_ready    = (state_q == ST_IDLE) && !acc_stat.init_busy;
	assign accept       = cmd_valid && cmd_ready;
	assign neuron_ext   = 32'(cmd.neuron);
	assign neuron_q_ext = 32'(neuron_q);
	assign next_row_ext = neuron_q_ext + 32'd1;
	assign slot_ext     = 32'(cmd.entry_slot);
	assign neuron_lt    = neuron_ext < NEURONS;

	assign row_we = accept && cmd.op == OP_ROW_START && neuron_ext <= NEURONS;
	assign ent_we = accept && cmd.op == OP_SYNAPSE && slot_ext < MAX_SYNAPSES;
	assign row_re = (accept && cmd.op == OP_SPIKE && neuron_lt) || state_q == ST_ROW0;
	assign row_rd_addr = (state_q == ST_ROW0) ? next_row_ext[RW-1:0] : neuron_ext[RW-1:0];
	assign issue  = state_q == ST_WALK && ptr_q < end_q;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[neuron_ext[RW-1:0]] <= cmd.row_start;
		end
		if (row_re) begin
			row_rd_q <= row_mem[row_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[slot_ext[EW-1:0]] <= '{target: cmd.target_column, weight: cmd.weight};
		end
		if (issue) begin
			ent_rd_q <= ent_mem[ptr_q[EW-1:0]];
		end
	end

	assign acc_cmd.add = ent_v_s1;
	assign acc_cmd.rd  = accept && cmd.op == OP_READ && neuron_lt;
	assign acc_cmd.clr = state_q == ST_READ && rsp_free;
	assign acc_idx     = (state_q == ST_READ) ? neuron_q_ext[NA-1:0] : neuron_ext[NA-1:0];

	cssa_acc_bank #(
		.NEURONS (NEURONS)
	) u_acc_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (acc_cmd),
		.idx     (acc_idx),
		.syn     (ent_rd_q),
		.rd_data (acc_rd_data),
		.stat    (acc_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ent_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			neuron_q    <= '0;
			start_q     <= '0;
			end_q       <= '0;
			ptr_q       <= '0;
			rsp_q       <= '0;
		end else begin
			ent_v_s1 <= issue;
			if (state_q == ST_READ && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neuron_q <= cmd.neuron;
						if (cmd.op == OP_SPIKE && neuron_lt) begin
							state_q <= ST_ROW0;
						end else if (cmd.op == OP_READ && neuron_lt) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_ROW0: begin
					start_q <= clamp_offset(row_rd_q);
					state_q <= ST_ROW1;
				end
				ST_ROW1: begin
					end_q   <= clamp_offset(row_rd_q);
					ptr_q   <= start_q;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!ent_v_s1 && !acc_stat.pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (rsp_free) begin
						rsp_q.read_neuron <= neuron_q[9:0];
						rsp_q.accumulated <= acc_rd_data;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import cssa_pkg::*;

	localparam int NEURONS      = NEURONS_DEF;
	localparam int SYNAPSES     = MAX_SYNAPSES_DEF;
	localparam int WINDOW       = 64;
	localparam int PITCH        = 24;
	localparam int RANDOM_ITEMS = 150;
	localparam int WATCHDOG     = 4000;
	localparam int SAT_SLOT     = 40000;
	localparam int SAT_LEN      = 512;
	localparam int SAT_SPIKES   = 260;
	localparam int SAT_ROW      = 600;

	localparam logic signed [31:0] ACC_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] ACC_MIN = 32'sh8000_0000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	csr_spike_scatter_accumulate_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Shadow of the block's memories, updated as items are accepted.
	logic [16:0]        rs_mem  [0:NEURONS];
	logic [9:0]         tgt_mem [0:SYNAPSES-1];
	logic signed [15:0] wgt_mem [0:SYNAPSES-1];
	logic signed [31:0] acc_mem [0:NEURONS-1];
	rsp_item_t          due_rsps[$];

	// What the stimulus generator has written so far, used to keep spikes legal.
	int        g_rs     [0:NEURONS];
	bit        g_rs_ok  [0:NEURONS];
	bit        g_ent_ok [0:SYNAPSES-1];
	int        hot_targets[$];
	cmd_item_t pending[$];

	int cmd_issued, cmd_accepted, mismatches, idle_cycles;
	int burst_left, gap_left, stall_left, stall_mode;
	int reads_checked, saturated_reads, spikes_fired, entries_walked;

	function automatic int clamp_off(int v);
		return (v > SYNAPSES) ? SYNAPSES : v;
	endfunction

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [15:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(ACC_MAX))
			return ACC_MAX;
		if (s < longint'(ACC_MIN))
			return ACC_MIN;
		return 32'(s);
	endfunction

	function automatic void fire_row(int r);
		int lo, hi;
		lo = clamp_off(int'(rs_mem[r]));
		hi = clamp_off(int'(rs_mem[r + 1]));
		spikes_fired++;
		for (int j = lo; j < hi; j++) begin
			entries_walked++;
			if (tgt_mem[j] < NEURONS)
				acc_mem[tgt_mem[j]] = sat_add(acc_mem[tgt_mem[j]], wgt_mem[j]);
		end
	endfunction

	task automatic apply_item(cmd_item_t it);
		rsp_item_t r;
		case (it.op)
			OP_ROW_START: begin
				if (it.neuron <= NEURONS)
					rs_mem[it.neuron] = it.row_start;
			end
			OP_SYNAPSE: begin
				tgt_mem[it.entry_slot] = it.target_column;
				wgt_mem[it.entry_slot] = it.weight;
			end
			OP_SPIKE: begin
				if (it.neuron < NEURONS)
					fire_row(int'(it.neuron));
			end
			OP_READ: begin
				if (it.neuron < NEURONS) begin
					r.read_neuron = it.neuron[9:0];
					r.accumulated = acc_mem[it.neuron];
					due_rsps.push_back(r);
					acc_mem[it.neuron] = '0;
				end
			end
		endcase
	endtask

	task automatic check_rsp(rsp_item_t got);
		rsp_item_t want;
		if (due_rsps.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result: neuron %0d value %0d", $time,
				got.read_neuron, got.accumulated);
			return;
		end
		want = due_rsps.pop_front();
		reads_checked++;
		if (want.accumulated == ACC_MAX || want.accumulated == ACC_MIN)
			saturated_reads++;
		if (got.read_neuron !== want.read_neuron) begin
			mismatches++;
			$display("%0t: read_neuron expected %0d actual %0d", $time,
				want.read_neuron, got.read_neuron);
		end
		if (got.accumulated !== want.accumulated) begin
			mismatches++;
			$display("%0t: accumulated of neuron %0d expected %0d actual %0d", $time,
				want.read_neuron, want.accumulated, got.accumulated);
		end
	endtask

	function automatic cmd_item_t noise(op_t op, int n);
		logic [95:0] bits;
		cmd_item_t   it;
		bits      = {$urandom, $urandom, $urandom};
		it        = bits[$bits(cmd_item_t)-1:0];
		it.op     = op;
		it.neuron = 11'(n);
		return it;
	endfunction

	task automatic send(cmd_item_t it);
		if (it.op == OP_ROW_START && it.neuron <= NEURONS) begin
			g_rs[it.neuron]    = int'(it.row_start);
			g_rs_ok[it.neuron] = 1'b1;
		end
		if (it.op == OP_SYNAPSE) begin
			g_ent_ok[it.entry_slot] = 1'b1;
			hot_targets.push_back(int'(it.target_column));
			if (hot_targets.size() > 32)
				void'(hot_targets.pop_front());
		end
		pending.push_back(it);
	endtask

	task automatic put_row_start(int n, int v);
		cmd_item_t it;
		it           = noise(OP_ROW_START, n);
		it.row_start = 17'(v);
		send(it);
	endtask

	task automatic put_synapse(int slot, int t, int w);
		cmd_item_t it;
		it               = noise(OP_SYNAPSE, $urandom_range(0, 2047));
		it.entry_slot    = 16'(slot);
		it.target_column = 10'(t);
		it.weight        = 16'(w);
		send(it);
	endtask

	task automatic put_spike(int n);
		send(noise(OP_SPIKE, n));
	endtask

	task automatic put_read(int n);
		send(noise(OP_READ, n));
	endtask

	// Number of entries a spike on row r walks, or -1 while a bound is unwritten.
	function automatic int row_gap(int r);
		int lo, hi;
		if (!g_rs_ok[r] || !g_rs_ok[r + 1])
			return -1;
		lo = clamp_off(g_rs[r]);
		hi = clamp_off(g_rs[r + 1]);
		return (hi > lo) ? hi - lo : 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_accepted == cmd_issued)) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				cmd       <= pending.pop_front();
				cmd_valid <= 1'b1;
				cmd_issued++;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 3) != 0);
			default: rsp_ready <= ($urandom_range(0, 4) < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (cmd_valid && cmd_ready) begin
				cmd_accepted++;
				idle_cycles = 0;
				apply_item(cmd);
			end
			if (rsp_valid && rsp_ready) begin
				idle_cycles = 0;
				check_rsp(rsp);
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, WATCHDOG, due_rsps.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int r, pick, span, lo, live, dice;
		for (int i = 0; i < NEURONS; i++)
			acc_mem[i] = '0;

		put_read(0);
		put_read(NEURONS - 1);
		put_read(NEURONS);
		put_read(2047);
		put_row_start(0, 0);
		put_row_start(1, 3);
		put_row_start(2, 3);
		put_row_start(3, 1);
		put_row_start(NEURONS - 1, SYNAPSES - 3);
		put_row_start(NEURONS, 100000);
		put_row_start(NEURONS + 1, 5);
		put_synapse(0, 0, 32767);
		put_synapse(1, NEURONS - 1, -32768);
		put_synapse(2, 5, 1);
		for (int j = SYNAPSES - 3; j < SYNAPSES; j++)
			put_synapse(j, $urandom_range(0, NEURONS - 1), $urandom);
		put_spike(0);
		put_spike(1);
		put_spike(2);
		put_spike(NEURONS - 1);
		put_spike(NEURONS);
		put_read(0);
		put_read(NEURONS - 1);
		put_read(5);

		// One row drives neuron 7 into positive and neuron 8 into negative saturation.
		for (int j = 0; j < SAT_LEN; j++)
			put_synapse(SAT_SLOT + j, (j % 2) ? 8 : 7, (j % 2) ? -32768 : 32767);
		put_row_start(SAT_ROW, SAT_SLOT);
		put_row_start(SAT_ROW + 1, SAT_SLOT + SAT_LEN);
		repeat (SAT_SPIKES)
			put_spike(SAT_ROW);
		put_read(7);
		put_read(8);

		live = 0;
		while (live < RANDOM_ITEMS) begin
			dice = $urandom_range(0, 99);
			if (dice < 15) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					r = $urandom_range(0, WINDOW);
				else if (pick < 92)
					r = $urandom_range(WINDOW + 1, NEURONS);
				else
					r = $urandom_range(NEURONS + 1, 2047);
				if ($urandom_range(0, 6) == 0)
					put_row_start(r, $urandom_range(0, 131071));
				else
					put_row_start(r, r * PITCH + $urandom_range(0, 30));
				if (r <= NEURONS)
					live++;
			end else if (dice < 35) begin
				if ($urandom_range(0, 3) == 0)
					r = $urandom_range(0, SYNAPSES - 1);
				else
					r = $urandom_range(0, WINDOW * PITCH + 60);
				put_synapse(r, $urandom_range(0, NEURONS - 1), $urandom);
				live++;
			end else if (dice < 65) begin
				if ($urandom_range(0, 5) == 0)
					r = $urandom_range(0, NEURONS - 1);
				else
					r = $urandom_range(0, WINDOW - 1);
				span = row_gap(r);
				if (span >= 0 && span <= 48) begin
					lo = clamp_off(g_rs[r]);
					for (int j = lo; j < lo + span; j++) begin
						if (!g_ent_ok[j]) begin
							put_synapse(j, $urandom_range(0, NEURONS - 1), $urandom);
							live++;
						end
					end
					put_spike(r);
					live++;
				end else if ($urandom_range(0, 7) == 0) begin
					put_spike($urandom_range(NEURONS, 2047));
				end
			end else begin
				if ($urandom_range(0, 6) == 0)
					r = $urandom_range(0, 2047);
				else if ($urandom_range(0, 1) == 0 && hot_targets.size() > 0)
					r = hot_targets[$urandom_range(0, hot_targets.size() - 1)];
				else
					r = $urandom_range(0, NEURONS - 1);
				put_read(r);
				if (r < NEURONS)
					live++;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || cmd_accepted != cmd_issued || due_rsps.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d items; %0d spikes walked %0d synapse entries in total.",
			cmd_accepted, spikes_fired, entries_walked);
		$display("Checked %0d accumulator reads, %0d of them at a saturation limit.",
			reads_checked, saturated_reads);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: csr_spike_scatter_accumulate_top.f
hdl/cssa_pkg.sv
hdl/cssa_acc_bank.sv
hdl/csr_spike_scatter_accumulate_top.sv
test/tb.sv
